[hw/rtl/cmdp_pkg.sv]
`timescale 1ns / 1ps

package cmdp_pkg;

  // register file
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_STRING_LENGTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ARGUMENT_COUNT = 8'd1;

  localparam logic [15:0] MAX_STRING_LENGTH_RST  = 16'd4096;
  localparam logic [7:0]  MAX_ARGUMENT_COUNT_RST = 8'd128;

  // byte role codes
  typedef enum logic [2:0] {
    ROLE_MAGIC   = 3'd0,
    ROLE_LENGTH  = 3'd1,
    ROLE_OP      = 3'd2,
    ROLE_IDEM    = 3'd3,
    ROLE_COUNT   = 3'd4,
    ROLE_ARG_KEY = 3'd5,
    ROLE_ARG_VAL = 3'd6,
    ROLE_NONE    = 3'd7
  } role_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_MAGIC = 3'd1,
    ERR_TOO_LONG  = 3'd2,
    ERR_TOO_MANY  = 3'd3,
    ERR_TRUNCATED = 3'd4,
    ERR_TRAILING  = 3'd5
  } err_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] byte_role;
    logic [7:0] arg_index;
    logic       string_end;
    logic       payload_done;
    logic       payload_ok;
    logic [2:0] error_code;
  } out_item_t;

  typedef struct packed {
    logic [15:0] max_string_length;
    logic [7:0]  max_argument_count;
  } cfg_regs_t;

  // magic "MCP1", one byte per position
  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = 8'h4D;
      2'd1:    b = 8'h43;
      2'd2:    b = 8'h50;
      default: b = 8'h31;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/cmdp_cfg.sv]
`timescale 1ns / 1ps

module cmdp_cfg #(
  parameter logic [15:0] MaxStringLengthRst  = cmdp_pkg::MAX_STRING_LENGTH_RST,
  parameter logic [7:0]  MaxArgumentCountRst = cmdp_pkg::MAX_ARGUMENT_COUNT_RST
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cmdp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cmdp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cmdp_pkg::cfg_regs_t              regs
);

  cmdp_pkg::cfg_regs_t regs_r;

  // writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.max_string_length  <= MaxStringLengthRst;
      regs_r.max_argument_count <= MaxArgumentCountRst;
    end else if (cfg_valid) begin
      if (cfg_index == cmdp_pkg::REG_MAX_STRING_LENGTH) begin
        regs_r.max_string_length <= cfg_data[15:0];
      end
      if (cfg_index == cmdp_pkg::REG_MAX_ARGUMENT_COUNT) begin
        regs_r.max_argument_count <= cfg_data[7:0];
      end
    end
  end

  assign regs = regs_r;

endmodule

[hw/rtl/cmdp_parse.sv]
`timescale 1ns / 1ps

module cmdp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  cmdp_pkg::in_item_t   item,
  input  cmdp_pkg::cfg_regs_t  regs,
  output cmdp_pkg::out_item_t  res
);

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_OP_LEN  = 4'd1,
    PH_OP_STR  = 4'd2,
    PH_KEY_LEN = 4'd3,
    PH_KEY_STR = 4'd4,
    PH_CNT     = 4'd5,
    PH_AK_LEN  = 4'd6,
    PH_AK_STR  = 4'd7,
    PH_AV_LEN  = 4'd8,
    PH_AV_STR  = 4'd9,
    PH_DONE    = 4'd10,
    PH_ERROR   = 4'd11
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic [23:0]       acc_r, acc_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [7:0]        args_total_r, args_total_nxt;
  logic [7:0]        args_done_r, args_done_nxt;
  cmdp_pkg::err_t    sticky_r, sticky_nxt;

  logic [31:0]       word;
  logic              pos_last;
  logic [7:0]        args_done_inc;
  phase_t            after_phase;
  logic              after_bump;
  cmdp_pkg::role_t   role;
  cmdp_pkg::err_t    err;
  cmdp_pkg::err_t    code;
  logic [7:0]        idx;
  logic              send;

  assign word          = {item.in_byte, acc_r};
  assign pos_last      = (pos_r == 2'd3);
  assign args_done_inc = args_done_r + 8'd1;

  // where the parse goes once the current string is complete
  always_comb begin
    after_bump = 1'b0;
    unique case (phase_r)
      PH_OP_LEN, PH_OP_STR:   after_phase = PH_KEY_LEN;
      PH_KEY_LEN, PH_KEY_STR: after_phase = PH_CNT;
      PH_AK_LEN, PH_AK_STR:   after_phase = PH_AV_LEN;
      default: begin
        after_bump  = 1'b1;
        after_phase = (args_done_inc == args_total_r) ? PH_DONE : PH_AK_LEN;
      end
    endcase
  end

  // one parse step per byte
  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    args_total_nxt = args_total_r;
    args_done_nxt  = args_done_r;
    sticky_nxt     = sticky_r;
    role           = cmdp_pkg::ROLE_NONE;
    err            = cmdp_pkg::ERR_NONE;
    idx            = 8'd0;
    send           = 1'b0;

    unique case (phase_r)
      PH_MAGIC: begin
        role = cmdp_pkg::ROLE_MAGIC;
        if (item.in_byte != cmdp_pkg::magic_byte(pos_r)) begin
          err = cmdp_pkg::ERR_BAD_MAGIC;
        end else if (pos_last) begin
          pos_nxt   = 2'd0;
          phase_nxt = PH_OP_LEN;
        end else begin
          pos_nxt = pos_r + 2'd1;
        end
      end
      PH_OP_LEN, PH_KEY_LEN, PH_AK_LEN, PH_AV_LEN: begin
        role = cmdp_pkg::ROLE_LENGTH;
        if (phase_r == PH_AK_LEN || phase_r == PH_AV_LEN) begin
          idx = args_done_r;
        end
        if (pos_last) begin
          pos_nxt = 2'd0;
          acc_nxt = 24'd0;
          if (word > {16'd0, regs.max_string_length}) begin
            err = cmdp_pkg::ERR_TOO_LONG;
          end else if (word == 32'd0) begin
            send = 1'b1;
          end else begin
            rem_nxt   = word[15:0];
            phase_nxt = phase_t'(phase_r + 4'd1);
          end
        end else begin
          acc_nxt[8*pos_r +: 8] = item.in_byte;
          pos_nxt               = pos_r + 2'd1;
        end
      end
      PH_OP_STR, PH_KEY_STR, PH_AK_STR, PH_AV_STR: begin
        unique case (phase_r)
          PH_OP_STR:  role = cmdp_pkg::ROLE_OP;
          PH_KEY_STR: role = cmdp_pkg::ROLE_IDEM;
          PH_AK_STR:  role = cmdp_pkg::ROLE_ARG_KEY;
          default:    role = cmdp_pkg::ROLE_ARG_VAL;
        endcase
        if (phase_r == PH_AK_STR || phase_r == PH_AV_STR) begin
          idx = args_done_r;
        end
        rem_nxt = rem_r - 16'd1;
        send    = (rem_nxt == 16'd0);
      end
      PH_CNT: begin
        role = cmdp_pkg::ROLE_COUNT;
        if (pos_last) begin
          pos_nxt = 2'd0;
          acc_nxt = 24'd0;
          if (word > {24'd0, regs.max_argument_count}) begin
            err = cmdp_pkg::ERR_TOO_MANY;
          end else begin
            args_total_nxt = word[7:0];
            args_done_nxt  = 8'd0;
            phase_nxt      = (word == 32'd0) ? PH_DONE : PH_AK_LEN;
          end
        end else begin
          acc_nxt[8*pos_r +: 8] = item.in_byte;
          pos_nxt               = pos_r + 2'd1;
        end
      end
      PH_DONE: begin
        err = cmdp_pkg::ERR_TRAILING;
      end
      default: begin
      end
    endcase

    // string complete: move to the next field
    if (send) begin
      phase_nxt = after_phase;
      if (after_bump) begin
        args_done_nxt = args_done_inc;
      end
    end

    // first error sticks until the final byte
    if (err != cmdp_pkg::ERR_NONE && sticky_r == cmdp_pkg::ERR_NONE) begin
      sticky_nxt = err;
      phase_nxt  = PH_ERROR;
    end

    code = sticky_nxt;
    if (item.in_last && code == cmdp_pkg::ERR_NONE && phase_nxt != PH_DONE) begin
      code = cmdp_pkg::ERR_TRUNCATED;
    end

    // the final byte starts a fresh payload
    if (item.in_last) begin
      phase_nxt      = PH_MAGIC;
      pos_nxt        = 2'd0;
      acc_nxt        = 24'd0;
      rem_nxt        = 16'd0;
      args_total_nxt = 8'd0;
      args_done_nxt  = 8'd0;
      sticky_nxt     = cmdp_pkg::ERR_NONE;
    end
  end

  // result fields
  always_comb begin
    res.out_byte     = item.in_byte;
    res.byte_role    = role;
    res.arg_index    = idx;
    res.string_end   = send;
    res.payload_done = item.in_last;
    res.payload_ok   = item.in_last && (code == cmdp_pkg::ERR_NONE);
    res.error_code   = code;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_MAGIC;
      pos_r        <= 2'd0;
      acc_r        <= 24'd0;
      rem_r        <= 16'd0;
      args_total_r <= 8'd0;
      args_done_r  <= 8'd0;
      sticky_r     <= cmdp_pkg::ERR_NONE;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      acc_r        <= acc_nxt;
      rem_r        <= rem_nxt;
      args_total_r <= args_total_nxt;
      args_done_r  <= args_done_nxt;
      sticky_r     <= sticky_nxt;
    end
  end

  // a pending error always parks the parser
  a_sticky_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (sticky_r != cmdp_pkg::ERR_NONE) |-> (phase_r == PH_ERROR))
    else $error("sticky error outside error phase");

  // string byte count only lives inside a string
  a_rem_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != 16'd0) |-> (phase_r == PH_OP_STR || phase_r == PH_KEY_STR ||
                          phase_r == PH_AK_STR || phase_r == PH_AV_STR))
    else $error("bytes remaining outside a string");

  // multi-byte position only in word fields, or frozen by a magic error
  a_pos_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != 2'd0) |-> (phase_r == PH_MAGIC || phase_r == PH_OP_LEN ||
                         phase_r == PH_KEY_LEN || phase_r == PH_CNT ||
                         phase_r == PH_AK_LEN || phase_r == PH_AV_LEN ||
                         phase_r == PH_ERROR))
    else $error("byte position outside a word field");

  // final byte returns the parser to the start
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && item.in_last) |=>
      (phase_r == PH_MAGIC && sticky_r == cmdp_pkg::ERR_NONE && pos_r == 2'd0))
    else $error("parser not cleared after final byte");

endmodule

[hw/rtl/command_payload_parser.sv]
`timescale 1ns / 1ps
// Command payload parser: tags each byte of an "MCP1" command payload.
// Input channel: one byte a beat (in_data.in_byte) with in_data.in_last on
// the final byte of a payload. Output channel: one result beat per input
// beat, in order, with the byte, its role, its argument index, a string-end
// flag and, on the final byte, payload_done/payload_ok and the error code.
// Configuration channel: cfg_index 0 writes the largest string length,
// cfg_index 1 the largest argument count; other indexes are ignored.
// cfg_ready is always high; write only while no payload byte is in flight.
// Path: a byte taken goes into the input register, then the output register, and shows on out_valid from there.
// Throughput: one byte per cycle while out_ready stays high, set by a single
// parse step between the input register and the output register.
// Reset: synchronous, active low; empties both registers, clears the parse
// state and loads the limits with 4096 and 128.
// Stall: while out_ready is low the output register holds its beat, the
// input register holds one more byte, and in_ready drops only when both
// are full. The parse state advances only when a byte moves to the output.
module command_payload_parser #(
  parameter logic [15:0] MaxStringLengthRst  = cmdp_pkg::MAX_STRING_LENGTH_RST,
  parameter logic [7:0]  MaxArgumentCountRst = cmdp_pkg::MAX_ARGUMENT_COUNT_RST
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cmdp_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cmdp_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cmdp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cmdp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  cmdp_pkg::cfg_regs_t regs;
  cmdp_pkg::in_item_t  s1_data_r;
  logic                s1_valid_r;
  cmdp_pkg::out_item_t out_data_r;
  logic                out_valid_r;
  cmdp_pkg::out_item_t res;
  logic                adv;

  cmdp_cfg #(
    .MaxStringLengthRst  (MaxStringLengthRst),
    .MaxArgumentCountRst (MaxArgumentCountRst)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // held byte moves on when the output slot is free or draining
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  cmdp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (s1_data_r),
    .regs    (regs),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
